FILE: src/pts_pkg.sv
// pts_pkg: shared types, constants and a helper function for the pan/tilt scan sequencer
`timescale 1ns / 1ps

package pts_pkg;

  // default angle width, Q3.12 radians
  localparam int ANGLE_WIDTH_DEF = 16;
  // width of the stored targets (clamped values fit with margin)
  localparam int TW              = 16;
  // configuration port
  localparam int CFG_W           = 13;
  localparam int CFG_IDX_W       = 2;
  localparam int TIMEOUT_W       = 8;
  localparam int COUNT_W         = 8;

  // scan geometry, Q3.12
  localparam logic signed [TW-1:0] TILT_MIN     = TW'(-2253);
  localparam logic signed [TW-1:0] TILT_MAX     = TW'(1352);
  localparam logic signed [TW-1:0] PAN_LIM_HIGH = TW'(5530);

  // register reset values
  localparam logic [CFG_W-1:0]     PAN_STEP_RST   = CFG_W'(1638);
  localparam logic [CFG_W-1:0]     TILT_STEP_RST  = CFG_W'(1229);
  localparam logic [CFG_W-1:0]     SETTLE_TOL_RST = CFG_W'(246);
  localparam logic [TIMEOUT_W-1:0] SETTLE_TMO_RST = TIMEOUT_W'(40);
  localparam logic [COUNT_W-1:0]   COUNT_MAX      = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAN_STEP   = 2'd0,
    REG_TILT_STEP  = 2'd1,
    REG_SETTLE_TOL = 2'd2,
    REG_SETTLE_TMO = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0]     pan_step;
    logic [CFG_W-1:0]     tilt_step;
    logic [CFG_W-1:0]     settle_tolerance;
    logic [TIMEOUT_W-1:0] settle_timeout;
  } cfg_t;

  typedef struct packed {
    logic               pan_dir_negative;
    logic               tilt_dir_up;
    logic [COUNT_W-1:0] settle_count;
  } scan_flags_t;

  // pan limit shrinks with tilt at a slope of 5/8, reduction truncated
  function automatic logic signed [TW-1:0] pan_limit(input logic signed [TW-1:0] tilt);
    logic signed [TW-1:0] d;
    logic signed [TW+2:0] d_ext;
    logic signed [TW+2:0] d5;
    d = TILT_MAX - tilt;
    if (d < 0) begin
      d = '0;
    end
    d_ext = (TW+3)'(d);
    d5    = (d_ext <<< 2) + d_ext;
    return PAN_LIM_HIGH - TW'(d5 >>> 3);
  endfunction

endpackage

FILE: src/pts_pan_step.sv
// pts_pan_step: one pan step toward the limit with clamp and direction reversal
`timescale 1ns / 1ps

module pts_pan_step import pts_pkg::*; #(
  parameter int IW = ANGLE_WIDTH_DEF + 2
) (
  input  logic signed [IW-1:0] pan_i,
  input  logic                 neg_i,
  input  logic [CFG_W-1:0]     step_i,
  input  logic signed [TW-1:0] tilt_i,
  output logic signed [TW-1:0] pan_o,
  output logic                 neg_o
);

  logic signed [TW-1:0] lim;
  logic signed [IW-1:0] lim_x;
  logic signed [IW-1:0] step_x;
  logic signed [IW-1:0] sum;
  logic signed [IW-1:0] mag;

  always_comb begin
    lim    = pan_limit(tilt_i);
    lim_x  = IW'(lim);
    step_x = signed'(IW'(step_i));
    sum    = neg_i ? (pan_i - step_x) : (pan_i + step_x);
    mag    = (sum < 0) ? -sum : sum;
    if (mag >= lim_x) begin
      // hit the limit: park there and turn around
      pan_o = neg_i ? -lim : lim;
      neg_o = !neg_i;
    end else begin
      pan_o = TW'(sum);
      neg_o = neg_i;
    end
  end

endmodule

FILE: src/pts_tick.sv
// pts_tick: combinational next-state and command logic for one control tick
`timescale 1ns / 1ps

module pts_tick import pts_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  cfg_t                          cfg_i,
  input  logic                          restart_i,
  input  logic signed [ANGLE_WIDTH-1:0] pan_meas_i,
  input  logic signed [ANGLE_WIDTH-1:0] tilt_meas_i,
  input  logic signed [TW-1:0]          pan_i,
  input  logic signed [TW-1:0]          tilt_i,
  input  scan_flags_t                   flags_i,
  output logic                          cmd_valid_o,
  output logic signed [TW-1:0]          pan_o,
  output logic signed [TW-1:0]          tilt_o,
  output scan_flags_t                   flags_o
);

  localparam int IW = ((ANGLE_WIDTH > TW) ? ANGLE_WIDTH : TW) + 2;

  function automatic logic signed [IW-1:0] clamp_tilt(input logic signed [IW-1:0] t);
    logic signed [IW-1:0] r;
    r = t;
    if (r >= IW'(TILT_MAX)) begin
      r = IW'(TILT_MAX);
    end
    if (r <= IW'(TILT_MIN)) begin
      r = IW'(TILT_MIN);
    end
    return r;
  endfunction

  function automatic logic signed [IW-1:0] abs_x(input logic signed [IW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  logic signed [IW-1:0]  pan_m_x;
  logic signed [IW-1:0]  tilt_m_x;
  logic signed [TW-1:0]  rs_tilt;
  logic                  rs_neg;
  logic signed [TW-1:0]  rs_pan_stepped;
  logic                  rs_neg_stepped;
  logic signed [TW-1:0]  cur_pan;
  logic signed [TW-1:0]  cur_tilt;
  logic                  cur_neg;
  logic                  cur_up;
  logic [COUNT_W-1:0]    cur_cnt;
  logic [COUNT_W-1:0]    cnt_inc;
  logic signed [IW-1:0]  cur_pan_x;
  logic signed [IW-1:0]  cur_tilt_x;
  logic signed [IW-1:0]  tilt_err;
  logic signed [IW-1:0]  pan_err;
  logic                  settled;
  logic                  advance;
  logic signed [IW-1:0]  lim_x;
  logic                  at_limit;
  logic signed [IW-1:0]  tstep_x;
  logic signed [IW-1:0]  tilt_next_x;
  logic signed [TW-1:0]  adv_pan;
  logic                  adv_neg;

  assign pan_m_x  = IW'(pan_meas_i);
  assign tilt_m_x = IW'(tilt_meas_i);

  // restart: new scan from the measured pose
  assign rs_neg  = !(pan_m_x > 0);
  assign rs_tilt = TW'(clamp_tilt(tilt_m_x));

  pts_pan_step #(
    .IW(IW)
  ) u_restart_step (
    .pan_i  (pan_m_x),
    .neg_i  (rs_neg),
    .step_i (cfg_i.pan_step),
    .tilt_i (rs_tilt),
    .pan_o  (rs_pan_stepped),
    .neg_o  (rs_neg_stepped)
  );

  always_comb begin
    if (restart_i) begin
      cur_pan  = rs_pan_stepped;
      cur_tilt = rs_tilt;
      cur_neg  = rs_neg_stepped;
      cur_up   = 1'b0;
      cur_cnt  = '0;
    end else begin
      cur_pan  = pan_i;
      cur_tilt = tilt_i;
      cur_neg  = flags_i.pan_dir_negative;
      cur_up   = flags_i.tilt_dir_up;
      cur_cnt  = flags_i.settle_count;
    end
  end

  assign cnt_inc    = (cur_cnt == COUNT_MAX) ? COUNT_MAX : cur_cnt + 1'b1;
  assign cur_pan_x  = IW'(cur_pan);
  assign cur_tilt_x = IW'(cur_tilt);
  assign tilt_err   = abs_x(cur_tilt_x - tilt_m_x);
  assign pan_err    = abs_x(cur_pan_x - pan_m_x);
  assign settled    = (tilt_err <= signed'(IW'(cfg_i.settle_tolerance))) &&
                      (pan_err  <= signed'(IW'(cfg_i.settle_tolerance)));
  assign advance    = settled || (cnt_inc >= COUNT_W'(cfg_i.settle_timeout));

  // at the pan limit the tilt moves instead of the pan
  assign lim_x    = IW'(pan_limit(cur_tilt));
  assign at_limit = abs_x(abs_x(cur_pan_x) - lim_x) <= signed'(IW'(cfg_i.settle_tolerance));

  assign tstep_x     = signed'(IW'(cfg_i.tilt_step));
  assign tilt_next_x = clamp_tilt(cur_up ? (cur_tilt_x - tstep_x) : (cur_tilt_x + tstep_x));

  pts_pan_step #(
    .IW(IW)
  ) u_scan_step (
    .pan_i  (cur_pan_x),
    .neg_i  (cur_neg),
    .step_i (cfg_i.pan_step),
    .tilt_i (cur_tilt),
    .pan_o  (adv_pan),
    .neg_o  (adv_neg)
  );

  always_comb begin
    pan_o                    = cur_pan;
    tilt_o                   = cur_tilt;
    flags_o.pan_dir_negative = cur_neg;
    flags_o.tilt_dir_up      = cur_up;
    flags_o.settle_count     = cnt_inc;
    if (advance) begin
      flags_o.settle_count = '0;
      if (at_limit) begin
        tilt_o = TW'(tilt_next_x);
        if (tilt_next_x >= IW'(TILT_MAX)) begin
          flags_o.tilt_dir_up = 1'b1;
        end else if (tilt_next_x <= IW'(TILT_MIN)) begin
          flags_o.tilt_dir_up = 1'b0;
        end
      end else begin
        pan_o                    = adv_pan;
        flags_o.pan_dir_negative = adv_neg;
      end
    end
  end

  assign cmd_valid_o = restart_i || advance;

endmodule

FILE: src/pan_tilt_scan_sequencer.sv
// pan_tilt_scan_sequencer: top level of the pan/tilt scan sequencer
`timescale 1ns / 1ps

// channel     direction  tdata (low bit up)                  tuser
// s_axis      in         pan_measured, tilt_measured         restart_scan
// m_axis      out        pan_command, tilt_command           command_valid
// cfg         in         cfg_we_i / cfg_idx_i / cfg_data_i   -
//
// one control tick per cycle sustained while m_axis is ready; a tick passes the input
// register, then the result register; the rate is set by the target/flag feedback
// loop through the tick logic
// reset clears targets, directions, settle counter, valid flags; config goes to defaults
// a stalled m_axis holds its transaction while one more tick waits in the
// input register; s_axis stalls only when both registers are full

module pan_tilt_scan_sequencer import pts_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // control ticks in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [((2*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata, // pan_measured, tilt_measured
  input  logic                 s_axis_tuser,               // restart_scan
  // head commands out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((2*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata, // pan_command, tilt_command
  output logic                 m_axis_tuser                // command_valid
);

  localparam int DW = ((2*ANGLE_WIDTH+7)/8)*8;
  localparam int IW = ((ANGLE_WIDTH > TW) ? ANGLE_WIDTH : TW) + 2;

  // configuration registers
  cfg_t cfg_q;

  // input register
  logic                          in_valid_q;
  logic                          in_restart_q;
  logic signed [ANGLE_WIDTH-1:0] in_pan_q;
  logic signed [ANGLE_WIDTH-1:0] in_tilt_q;

  // scan state
  logic signed [TW-1:0] target_pan_q,  target_pan_d;
  logic signed [TW-1:0] target_tilt_q, target_tilt_d;
  scan_flags_t          flags_q,       flags_d;

  // result register
  logic                          out_valid_q;
  logic                          out_cmd_valid_q, out_cmd_valid_d;
  logic signed [ANGLE_WIDTH-1:0] out_pan_q;
  logic signed [ANGLE_WIDTH-1:0] out_tilt_q;

  logic out_free;
  logic fire;
  logic in_take;
  logic signed [IW-1:0] pan_cmd_x;
  logic signed [IW-1:0] tilt_cmd_x;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // register writes; write only while idle (the block itself does not enforce it)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan_step         <= PAN_STEP_RST;
      cfg_q.tilt_step        <= TILT_STEP_RST;
      cfg_q.settle_tolerance <= SETTLE_TOL_RST;
      cfg_q.settle_timeout   <= SETTLE_TMO_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PAN_STEP:   cfg_q.pan_step         <= cfg_data_i;
        REG_TILT_STEP:  cfg_q.tilt_step        <= cfg_data_i;
        REG_SETTLE_TOL: cfg_q.settle_tolerance <= cfg_data_i;
        REG_SETTLE_TMO: cfg_q.settle_timeout   <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state and command for the tick in the input register
  pts_tick #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_tick (
    .cfg_i       (cfg_q),
    .restart_i   (in_restart_q),
    .pan_meas_i  (in_pan_q),
    .tilt_meas_i (in_tilt_q),
    .pan_i       (target_pan_q),
    .tilt_i      (target_tilt_q),
    .flags_i     (flags_q),
    .cmd_valid_o (out_cmd_valid_d),
    .pan_o       (target_pan_d),
    .tilt_o      (target_tilt_d),
    .flags_o     (flags_d)
  );

  // control: valid flags and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      target_pan_q  <= '0;
      target_tilt_q <= '0;
      flags_q       <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q   <= 1'b1;
        target_pan_q  <= target_pan_d;
        target_tilt_q <= target_tilt_d;
        flags_q       <= flags_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // commands are the new targets, sized to the angle width
  assign pan_cmd_x  = IW'(target_pan_d);
  assign tilt_cmd_x = IW'(target_tilt_d);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_restart_q <= s_axis_tuser;
      in_pan_q     <= s_axis_tdata[ANGLE_WIDTH-1:0];
      in_tilt_q    <= s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH];
    end
    if (fire) begin
      out_cmd_valid_q <= out_cmd_valid_d;
      out_pan_q       <= pan_cmd_x[ANGLE_WIDTH-1:0];
      out_tilt_q      <= tilt_cmd_x[ANGLE_WIDTH-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_cmd_valid_q;
  assign m_axis_tdata  = DW'({out_tilt_q, out_pan_q});

endmodule

FILE: sim/tb_pan_tilt_scan_sequencer.sv
// tb_pan_tilt_scan_sequencer: self-checking testbench for the pan/tilt scan sequencer
`timescale 1ns / 1ps

module tb_pan_tilt_scan_sequencer;
  import pts_pkg::*;

  localparam int DATA_W   = ((2*ANGLE_WIDTH_DEF+7)/8)*8;
  localparam int WATCHDOG = 1000;
  localparam int TILT_HI  = TILT_MAX;
  localparam int TILT_LO  = TILT_MIN;
  localparam int PAN_HI   = PAN_LIM_HIGH;
  localparam int SAT      = COUNT_MAX;

  // one control tick and one head command as the scoreboard sees them
  typedef struct {
    bit      restart;
    shortint pan;
    shortint tilt;
  } tick_t;

  typedef struct {
    bit      valid;
    shortint pan;
    shortint tilt;
  } head_cmd_t;

  // scan state kept by the predictor
  typedef struct {
    int target_pan;
    int target_tilt;
    bit pan_neg;
    bit tilt_up;
    int settle_count;
  } scan_state_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]  cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // pan_measured, tilt_measured
  logic              s_axis_tuser  = 1'b0; // restart_scan
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // pan_command, tilt_command
  logic              m_axis_tuser;        // command_valid

  pan_tilt_scan_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  cfg_t        scan_cfg;
  scan_state_t plan_state;   // advanced as ticks are queued, lets stimulus follow the target
  scan_state_t head_state;   // advanced as ticks are accepted
  tick_t       pending_ticks[$];
  head_cmd_t   expected_cmds[$];
  int          stall_odds  = 0;
  int          src_gap     = 0;
  int          sink_gap    = 0;
  int          idle_cycles = 0;
  int          errors      = 0;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_tilt(input int t);
    if (t >= TILT_HI) t = TILT_HI;
    if (t <= TILT_LO) t = TILT_LO;
    return t;
  endfunction

  // pan reach shrinks with tilt at 5/8, reduction truncated
  function automatic int pan_reach(input int tilt);
    int d;
    d = TILT_HI - tilt;
    if (d < 0) d = 0;
    return PAN_HI - (d * 5) / 8;
  endfunction

  // one pan step in the current direction, clamped at the reach with reversal
  function automatic void step_pan(inout scan_state_t st, input cfg_t cf);
    int lim;
    int dir;
    int ps;
    lim = pan_reach(st.target_tilt);
    dir = st.pan_neg ? -1 : 1;
    ps  = cf.pan_step;
    st.target_pan = st.target_pan + dir * ps;
    if (mag(st.target_pan) >= lim) begin
      st.target_pan = dir * lim;
      st.pan_neg = !st.pan_neg;
    end
  endfunction

  function automatic head_cmd_t scan_tick(inout scan_state_t st, input cfg_t cf,
                                          input tick_t tk);
    int        pm;
    int        tm;
    int        tol;
    int        tmo;
    int        ts;
    int        dir;
    bit        issue;
    head_cmd_t r;
    pm    = tk.pan;
    tm    = tk.tilt;
    tol   = cf.settle_tolerance;
    tmo   = cf.settle_timeout;
    ts    = cf.tilt_step;
    issue = 1'b0;
    if (tk.restart) begin
      st.pan_neg     = !(pm > 0);
      st.target_tilt = clamp_tilt(tm);
      st.target_pan  = pm;
      step_pan(st, cf);
      st.tilt_up      = 1'b0;
      st.settle_count = 0;
      issue = 1'b1;
    end
    if (st.settle_count < SAT) st.settle_count++;
    if ((mag(st.target_tilt - tm) <= tol && mag(st.target_pan - pm) <= tol) ||
        st.settle_count >= tmo) begin
      st.settle_count = 0;
      if (mag(mag(st.target_pan) - pan_reach(st.target_tilt)) <= tol) begin
        // at the pan limit: tilt steps and bounces between its bounds
        dir = st.tilt_up ? -1 : 1;
        st.target_tilt = clamp_tilt(st.target_tilt + dir * ts);
        if (st.target_tilt >= TILT_HI) st.tilt_up = 1'b1;
        else if (st.target_tilt <= TILT_LO) st.tilt_up = 1'b0;
      end else begin
        step_pan(st, cf);
      end
      issue = 1'b1;
    end
    r.valid = issue;
    r.pan   = shortint'(st.target_pan);
    r.tilt  = shortint'(st.target_tilt);
    return r;
  endfunction

  task automatic queue_tick(input bit restart, input int pan, input int tilt);
    tick_t     tk;
    head_cmd_t unused;
    tk.restart = restart;
    tk.pan     = shortint'(pan);
    tk.tilt    = shortint'(tilt);
    unused = scan_tick(plan_state, scan_cfg, tk);
    pending_ticks.push_back(tk);
  endtask

  // measured pose close to the planned target, so most ticks can settle
  task automatic queue_follow(input int spread);
    queue_tick(1'b0,
               plan_state.target_pan + $urandom_range(0, 2*spread) - spread,
               plan_state.target_tilt + $urandom_range(0, 2*spread) - spread);
  endtask

  task automatic queue_random(input int count);
    int r;
    int tol;
    tol = scan_cfg.settle_tolerance;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 5) begin
        // restart, mostly near the scan envelope, sometimes anywhere
        if ($urandom_range(3) == 0)
          queue_tick(1'b1, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
        else
          queue_tick(1'b1, $urandom_range(12000) - 6000, $urandom_range(6000) - 3500);
      end else if (r < 85) begin
        queue_follow(tol + 2);
      end else begin
        // noise across the full angle range
        queue_tick(1'b0, $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
      end
    end
  endtask

  task automatic load_config(input int ps, input int ts, input int tol, input int tmo);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_PAN_STEP;   cfg_data_i <= CFG_W'(ps);
    scan_cfg.pan_step = CFG_W'(ps);
    @(posedge clk_i);
    cfg_idx_i <= REG_TILT_STEP;  cfg_data_i <= CFG_W'(ts);
    scan_cfg.tilt_step = CFG_W'(ts);
    @(posedge clk_i);
    cfg_idx_i <= REG_SETTLE_TOL; cfg_data_i <= CFG_W'(tol);
    scan_cfg.settle_tolerance = CFG_W'(tol);
    @(posedge clk_i);
    cfg_idx_i <= REG_SETTLE_TMO; cfg_data_i <= CFG_W'(tmo);
    scan_cfg.settle_timeout = TIMEOUT_W'(tmo);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued tick has gone in and every command has come out
  task automatic drain();
    while (pending_ticks.size() > 0 || s_axis_tvalid || expected_cmds.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // tick source with random idle bursts
  always @(posedge clk_i) begin : tick_source
    tick_t tk;
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (src_gap > 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0 && stall_odds > 0 &&
                   $urandom_range(99) < stall_odds) begin
        src_gap       <= $urandom_range(7);
        s_axis_tvalid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        tk = pending_ticks.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {16'(tk.tilt), 16'(tk.pan)};
        s_axis_tuser  <= tk.restart;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // command sink with random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap      <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_odds > 0 && $urandom_range(99) < stall_odds) begin
        sink_gap      <= $urandom_range(7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // predict on accepted ticks, check accepted commands, watch for a hang
  always @(posedge clk_i) begin : scoreboard
    tick_t     tk;
    head_cmd_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: command with none expected: valid %0b pan %0d tilt %0d", $time,
                   m_axis_tuser, $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          if (m_axis_tuser !== want.valid) begin
            $display("%0t: command_valid expected %0b got %0b", $time, want.valid,
                     m_axis_tuser);
            errors++;
          end
          if ($signed(m_axis_tdata[15:0]) !== want.pan) begin
            $display("%0t: pan_command expected %0d got %0d", $time, want.pan,
                     $signed(m_axis_tdata[15:0]));
            errors++;
          end
          if ($signed(m_axis_tdata[31:16]) !== want.tilt) begin
            $display("%0t: tilt_command expected %0d got %0d", $time, want.tilt,
                     $signed(m_axis_tdata[31:16]));
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tk.restart = s_axis_tuser;
        tk.pan     = s_axis_tdata[15:0];
        tk.tilt    = s_axis_tdata[31:16];
        expected_cmds.push_back(scan_tick(head_state, scan_cfg, tk));
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    scan_cfg   = '{PAN_STEP_RST, TILT_STEP_RST, SETTLE_TOL_RST, SETTLE_TMO_RST};
    plan_state = '{0, 0, 1'b0, 1'b0, 0};
    head_state = plan_state;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks on the reset configuration
    stall_odds = 15;
    queue_tick(1'b0, 0, 0);                // settled at reset pose, pan steps
    queue_tick(1'b1, 0, 0);                // restart at zero pan goes negative
    queue_tick(1'b1, 32767, 32767);        // clamps to the top tilt and full pan reach
    queue_follow(0);                       // at the pan limit: tilt hits its top bound
    queue_follow(0);                       // tilt bounces back down
    queue_tick(1'b1, -32768, -32768);      // bottom tilt, narrowest pan reach
    queue_tick(1'b1, 1, 1352);             // smallest positive pan, tilt exactly at top
    queue_tick(1'b1, 5500, 1352);          // restart that settles on the same tick
    queue_tick(1'b1, 0, -2253);            // tilt exactly at bottom
    repeat (13) queue_follow(0);           // sweep across and bounce the tilt
    queue_tick(1'b0, -1, -1);
    queue_tick(1'b0, 32767, -32768);
    queue_random(276);
    drain();

    // widest steps and tolerance, advance on every tick
    load_config(4096, 4096, 4096, 1);
    stall_odds = 30;
    queue_random(300);
    drain();

    // frozen steps, exact settling only, longest timeout; no idling here
    load_config(0, 0, 0, 255);
    stall_odds = 0;
    queue_random(300);
    drain();

    // zero timeout advances every tick
    load_config($urandom_range(4096), $urandom_range(4096), $urandom_range(600), 0);
    stall_odds = 20;
    queue_random(250);
    drain();

    load_config($urandom_range(4096), $urandom_range(4096), $urandom_range(4096),
                $urandom_range(1, 255));
    stall_odds = 10;
    queue_random(300);
    drain();

    // back to reset values, full rate on both sides to the end
    load_config(PAN_STEP_RST, TILT_STEP_RST, SETTLE_TOL_RST, SETTLE_TMO_RST);
    stall_odds = 0;
    queue_random(400);
    drain();
    repeat (8) @(posedge clk_i);

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
